>>> rtl/core/parm_pkg.sv
// ----------------------------------------------------------------------------
// parm_pkg
// Shared widths, command and status codes, sequencer states and the
// cross-product step table of the polygon area relocation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package parm_pkg;

  // Default sizing of the ring and of the stored coordinates
  localparam int DEF_MAX_POINTS = 256;
  localparam int DEF_COORD_BITS = 16;

  // Fixed field widths of the request and result channels
  localparam int CMD_BITS         = 2;
  localparam int FIELD_COORD_BITS = 16;
  localparam int INDEX_BITS       = 8;
  localparam int AREA_BITS        = 41;
  localparam int COUNT_BITS       = 9;
  localparam int STATUS_BITS      = 2;

  // Request commands
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_EVAL   = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_APPLY  = 2'd3;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_RANGE = 2'd2;

  // Point roles. An append reuses the first three: last point, new point
  // and first point.
  localparam int ROLE_BITS = 3;
  localparam logic [ROLE_BITS-1:0] ROLE_PREV   = 3'd0;
  localparam logic [ROLE_BITS-1:0] ROLE_FROM   = 3'd1;
  localparam logic [ROLE_BITS-1:0] ROLE_NEXT   = 3'd2;
  localparam logic [ROLE_BITS-1:0] ROLE_PRE_TO = 3'd3;
  localparam logic [ROLE_BITS-1:0] ROLE_TO     = 3'd4;

  localparam int STEP_BITS        = 4;
  localparam int MAC_STEPS_APPEND = 6;
  localparam int MAC_STEPS_EVAL   = 12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_SETTLE,
    ST_AREA,
    ST_ENERGY,
    ST_SHIFT,
    ST_PLACE,
    ST_DONE
  } parm_state_t;

  // Control travelling with the operands into the accumulator
  typedef struct packed {
    logic clr;
    logic en;
    logic neg;
  } mac_ctl_t;

  // One product term: x of the point in role_x times y of the point in role_y
  typedef struct packed {
    logic [ROLE_BITS-1:0] role_x;
    logic [ROLE_BITS-1:0] role_y;
    logic                 neg;
  } mac_step_t;

  // Each cross(a, b) = ax*by - bx*ay expands into two terms.
  function automatic mac_step_t mac_step(input logic append, input logic [STEP_BITS-1:0] k);
    mac_step_t s;
    s = '{ROLE_PREV, ROLE_PREV, 1'b0};
    if (append) begin
      // + cross(last, new) + cross(new, first) - cross(last, first)
      case (k)
        4'd0:    s = '{ROLE_PREV, ROLE_FROM, 1'b0};
        4'd1:    s = '{ROLE_FROM, ROLE_PREV, 1'b1};
        4'd2:    s = '{ROLE_FROM, ROLE_NEXT, 1'b0};
        4'd3:    s = '{ROLE_NEXT, ROLE_FROM, 1'b1};
        4'd4:    s = '{ROLE_PREV, ROLE_NEXT, 1'b1};
        4'd5:    s = '{ROLE_NEXT, ROLE_PREV, 1'b0};
        default: s = '{ROLE_PREV, ROLE_PREV, 1'b0};
      endcase
    end else begin
      // + cross(p, nx) + cross(pt, f) + cross(f, t)
      // - cross(p, f) - cross(f, nx) - cross(pt, t)
      case (k)
        4'd0:    s = '{ROLE_PREV,   ROLE_NEXT,   1'b0};
        4'd1:    s = '{ROLE_NEXT,   ROLE_PREV,   1'b1};
        4'd2:    s = '{ROLE_PRE_TO, ROLE_FROM,   1'b0};
        4'd3:    s = '{ROLE_FROM,   ROLE_PRE_TO, 1'b1};
        4'd4:    s = '{ROLE_FROM,   ROLE_TO,     1'b0};
        4'd5:    s = '{ROLE_TO,     ROLE_FROM,   1'b1};
        4'd6:    s = '{ROLE_PREV,   ROLE_FROM,   1'b1};
        4'd7:    s = '{ROLE_FROM,   ROLE_PREV,   1'b0};
        4'd8:    s = '{ROLE_FROM,   ROLE_NEXT,   1'b1};
        4'd9:    s = '{ROLE_NEXT,   ROLE_FROM,   1'b0};
        4'd10:   s = '{ROLE_PRE_TO, ROLE_TO,     1'b1};
        4'd11:   s = '{ROLE_TO,     ROLE_PRE_TO, 1'b0};
        default: s = '{ROLE_PREV,   ROLE_PREV,   1'b0};
      endcase
    end
    return s;
  endfunction

endpackage

>>> rtl/core/parm_if.sv
// ----------------------------------------------------------------------------
// parm_if
// Valid/ready channels of the polygon area relocation block: the request
// channel and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface parm_in_if;
  logic                                        valid;
  logic                                        ready;
  logic        [parm_pkg::CMD_BITS-1:0]         cmd;
  logic signed [parm_pkg::FIELD_COORD_BITS-1:0] point_x;
  logic signed [parm_pkg::FIELD_COORD_BITS-1:0] point_y;
  logic        [parm_pkg::INDEX_BITS-1:0]       from_index;
  logic        [parm_pkg::INDEX_BITS-1:0]       to_index;

  modport source (output valid, cmd, point_x, point_y, from_index, to_index,
                  input ready);
  modport sink   (input valid, cmd, point_x, point_y, from_index, to_index,
                  output ready);
endinterface

interface parm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [parm_pkg::AREA_BITS-1:0]  doubled_area;
  logic signed [parm_pkg::AREA_BITS-1:0]  area_change;
  logic signed [parm_pkg::AREA_BITS-1:0]  energy_change;
  logic        [parm_pkg::COUNT_BITS-1:0]  point_count;
  logic        [parm_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, doubled_area, area_change, energy_change, point_count,
                  status, input ready);
  modport sink   (input valid, doubled_area, area_change, energy_change, point_count,
                  status, output ready);
endinterface

>>> rtl/core/parm_mac.sv
// ----------------------------------------------------------------------------
// parm_mac
// Cross-product accumulator: one registered signed product per cycle, added
// to or subtracted from a doubled-area sum that wraps at the area width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parm_mac #(
  parameter int COORD_BITS = parm_pkg::DEF_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  parm_pkg::mac_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0]          op_x,
  input  logic signed [COORD_BITS-1:0]          op_y,
  output logic signed [parm_pkg::AREA_BITS-1:0] acc
);

  localparam int PW = 2 * COORD_BITS;
  localparam int EW = (PW > parm_pkg::AREA_BITS) ? PW : parm_pkg::AREA_BITS;

  logic signed [PW-1:0]                  prod_r;
  logic                                  pv_r;
  logic                                  pneg_r;
  logic signed [EW-1:0]                  prod_e;
  logic signed [parm_pkg::AREA_BITS-1:0] term;
  logic signed [parm_pkg::AREA_BITS-1:0] acc_r;

  // widen or drop the top of the product, the sum wraps anyway
  assign prod_e = EW'(prod_r);
  assign term   = prod_e[parm_pkg::AREA_BITS-1:0];
  assign acc    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(op_x) * PW'(op_y);
    pneg_r <= ctl.neg;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= pneg_r ? (acc_r - term) : (acc_r + term);
    end
  end

endmodule

>>> rtl/core/polygon_area_relocation_move.sv
// ----------------------------------------------------------------------------
// polygon_area_relocation_move
// Holds a closed polygon as a ring of points in a synchronous memory, with
// its signed doubled shoelace area. Requests clear the ring, append a point,
// or evaluate or apply moving the point at from_index to just before
// to_index; every request returns one result with the area after it, the
// area and energy change of the move, the point count and a status.
// One request is worked at a time. Clear, a full ring, an index not below
// the count, an append to an empty ring and a trivial move need no
// arithmetic. Other appends and moves use the single multiplier, which
// forms one product term per cycle (six terms per append, twelve per move);
// an apply then shifts the entries between the two positions that move by
// one place through the memory write port, one entry per cycle. A finished
// result waits in an output register, and the next request is taken while
// it waits. No clearing pass follows reset: an entry is read only after it
// has been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_area_relocation_move #(
  parameter int MAX_POINTS = parm_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = parm_pkg::DEF_COORD_BITS
) (
  input logic       clk,
  input logic       rst_n,
  parm_in_if.sink   in_ch,
  parm_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_POINTS);        // ring address
  localparam int CW = $clog2(MAX_POINTS + 1);    // point count
  localparam int IW = (CW > parm_pkg::INDEX_BITS) ? CW : parm_pkg::INDEX_BITS;
  localparam int DW = 2 * COORD_BITS;            // one entry: x above y
  localparam int AB = parm_pkg::AREA_BITS;

  // --------------------------------------------------------------------------
  // State and working registers
  // --------------------------------------------------------------------------
  parm_pkg::parm_state_t state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic signed [AB-1:0]            area_r, area_nxt;
  logic [parm_pkg::CMD_BITS-1:0]   cmd_r, cmd_nxt;

  // ring positions of the points a request works on
  logic [AW-1:0] ip_r, ip_nxt;       // predecessor of from / last point
  logic [AW-1:0] if_r, if_nxt;       // from / new point
  logic [AW-1:0] inx_r, inx_nxt;     // successor of from / first point
  logic [AW-1:0] ipt_r, ipt_nxt;     // predecessor of to
  logic [AW-1:0] it_r, it_nxt;       // to

  logic [parm_pkg::STEP_BITS-1:0] k_r, k_nxt;
  parm_pkg::mac_ctl_t             mac_ctl_r, mac_ctl_nxt;
  parm_pkg::mac_step_t            step;
  logic                           is_append;

  logic signed [AB-1:0] new_area_r, new_area_nxt;
  logic signed [AB-1:0] abs_old_r, abs_old_nxt;
  logic signed [AB-1:0] res_da_r, res_da_nxt;
  logic signed [AB-1:0] res_de_r, res_de_nxt;
  logic [parm_pkg::STATUS_BITS-1:0] res_st_r, res_st_nxt;

  // relocation shift
  logic [DW-1:0] moved_r, moved_nxt;
  logic          sh_up_r, sh_up_nxt;
  logic [AW-1:0] sh_rd_r, sh_rd_nxt;
  logic [AW-1:0] sh_left_r, sh_left_nxt;
  logic          sh_wv_r, sh_wv_nxt;
  logic [AW-1:0] sh_wa_r, sh_wa_nxt;
  logic [AW-1:0] dest_r, dest_nxt;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_load;
  logic signed [AB-1:0]              out_area_r;
  logic signed [AB-1:0]              out_da_r;
  logic signed [AB-1:0]              out_de_r;
  logic [parm_pkg::COUNT_BITS-1:0]   out_cnt_r;
  logic [parm_pkg::STATUS_BITS-1:0]  out_st_r;

  // point memory
  logic [DW-1:0] mem [MAX_POINTS];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  logic [AW-1:0] ra_a, ra_b;
  logic [DW-1:0] rd_a_r, rd_b_r;

  logic signed [AB-1:0] mac_acc;

  // request decode
  logic [IW-1:0]         from_w, to_w, cnt_w;
  logic [AW-1:0]         f_a, t_a, last_a, nx_a, pv_a, pt_a;
  logic                  idx_bad, move_trivial;
  logic [COORD_BITS-1:0] x_c, y_c;

  // --------------------------------------------------------------------------
  // Point memory: one write port, two registered read ports
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  // --------------------------------------------------------------------------
  // Cross-product accumulator: x from read port A, y from read port B
  // --------------------------------------------------------------------------
  parm_mac #(
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl_r),
    .op_x  (signed'(rd_a_r[DW-1:COORD_BITS])),
    .op_y  (signed'(rd_b_r[COORD_BITS-1:0])),
    .acc   (mac_acc)
  );

  function automatic logic [AW-1:0] role_addr(
    input logic [parm_pkg::ROLE_BITS-1:0] role,
    input logic [AW-1:0] a_prev, input logic [AW-1:0] a_from, input logic [AW-1:0] a_next,
    input logic [AW-1:0] a_pre_to, input logic [AW-1:0] a_to);
    logic [AW-1:0] a;
    case (role)
      parm_pkg::ROLE_PREV:   a = a_prev;
      parm_pkg::ROLE_FROM:   a = a_from;
      parm_pkg::ROLE_NEXT:   a = a_next;
      parm_pkg::ROLE_PRE_TO: a = a_pre_to;
      parm_pkg::ROLE_TO:     a = a_to;
      default:               a = a_prev;
    endcase
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Request decode: range check, ring neighbours, trivial move
  // --------------------------------------------------------------------------
  always_comb begin
    from_w  = IW'(in_ch.from_index);
    to_w    = IW'(in_ch.to_index);
    cnt_w   = IW'(count_r);
    idx_bad = (from_w >= cnt_w) || (to_w >= cnt_w);
    // positions fit the address once the range check has passed
    f_a    = AW'(in_ch.from_index);
    t_a    = AW'(in_ch.to_index);
    last_a = AW'(count_r - CW'(1));
    nx_a   = (f_a == last_a) ? '0 : (f_a + AW'(1));
    pv_a   = (f_a == '0) ? last_a : (f_a - AW'(1));
    pt_a   = (t_a == '0) ? last_a : (t_a - AW'(1));
    move_trivial = (count_r < CW'(2)) || (f_a == t_a) || (nx_a == t_a);
    // low coordinate bits taken as two's complement, a short field widened
    // with zeros
    x_c = COORD_BITS'(in_ch.point_x[parm_pkg::FIELD_COORD_BITS-1:0]);
    y_c = COORD_BITS'(in_ch.point_y[parm_pkg::FIELD_COORD_BITS-1:0]);
  end

  assign is_append = (cmd_r == parm_pkg::CMD_APPEND);
  assign step      = parm_pkg::mac_step(is_append, k_r);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    area_nxt     = area_r;
    cmd_nxt      = cmd_r;
    ip_nxt       = ip_r;
    if_nxt       = if_r;
    inx_nxt      = inx_r;
    ipt_nxt      = ipt_r;
    it_nxt       = it_r;
    k_nxt        = k_r;
    mac_ctl_nxt  = '0;
    new_area_nxt = new_area_r;
    abs_old_nxt  = abs_old_r;
    res_da_nxt   = res_da_r;
    res_de_nxt   = res_de_r;
    res_st_nxt   = res_st_r;
    moved_nxt    = moved_r;
    sh_up_nxt    = sh_up_r;
    sh_rd_nxt    = sh_rd_r;
    sh_left_nxt  = sh_left_r;
    sh_wv_nxt    = 1'b0;
    sh_wa_nxt    = sh_wa_r;
    dest_nxt     = dest_r;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = sh_wa_r;
    mem_wd       = rd_a_r;
    ra_a         = sh_rd_r;
    ra_b         = if_r;

    case (state_r)
      parm_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          // take the request; cases that need no arithmetic finish at once
          cmd_nxt         = in_ch.cmd;
          res_da_nxt      = '0;
          res_de_nxt      = '0;
          res_st_nxt      = parm_pkg::STAT_OK;
          k_nxt           = '0;
          mac_ctl_nxt.clr = 1'b1;
          state_nxt       = parm_pkg::ST_DONE;
          case (in_ch.cmd)
            parm_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              area_nxt  = '0;
            end
            parm_pkg::CMD_APPEND: begin
              if (count_r == CW'(MAX_POINTS)) begin
                res_st_nxt = parm_pkg::STAT_FULL;
              end else begin
                // store the point now, the term reads pick it up later
                mem_we = 1'b1;
                mem_wa = AW'(count_r);
                mem_wd = {x_c, y_c};
                if (count_r == '0) begin
                  count_nxt = CW'(1);
                end else begin
                  ip_nxt    = last_a;
                  if_nxt    = AW'(count_r);
                  inx_nxt   = '0;
                  state_nxt = parm_pkg::ST_MAC;
                end
              end
            end
            default: begin
              if (idx_bad) begin
                res_st_nxt = parm_pkg::STAT_RANGE;
              end else if (!move_trivial) begin
                ip_nxt    = pv_a;
                if_nxt    = f_a;
                inx_nxt   = nx_a;
                ipt_nxt   = pt_a;
                it_nxt    = t_a;
                state_nxt = parm_pkg::ST_MAC;
              end
            end
          endcase
        end
      end

      parm_pkg::ST_MAC: begin
        // read the two points of one product term, accumulate it later
        ra_a        = role_addr(step.role_x, ip_r, if_r, inx_r, ipt_r, it_r);
        ra_b        = role_addr(step.role_y, ip_r, if_r, inx_r, ipt_r, it_r);
        mac_ctl_nxt = '{clr: 1'b0, en: 1'b1, neg: step.neg};
        k_nxt       = k_r + parm_pkg::STEP_BITS'(1);
        if ((is_append && (k_r == parm_pkg::STEP_BITS'(parm_pkg::MAC_STEPS_APPEND - 1))) ||
            (!is_append && (k_r == parm_pkg::STEP_BITS'(parm_pkg::MAC_STEPS_EVAL - 1)))) begin
          state_nxt = parm_pkg::ST_FLUSH;
        end
      end

      parm_pkg::ST_FLUSH: begin
        state_nxt = parm_pkg::ST_SETTLE;
      end

      parm_pkg::ST_SETTLE: begin
        state_nxt = parm_pkg::ST_AREA;
      end

      parm_pkg::ST_AREA: begin
        if (is_append) begin
          area_nxt  = area_r + mac_acc;
          count_nxt = count_r + CW'(1);
          state_nxt = parm_pkg::ST_DONE;
        end else begin
          new_area_nxt = area_r + mac_acc;
          abs_old_nxt  = area_r[AB-1] ? -area_r : area_r;
          res_da_nxt   = mac_acc;
          ra_b         = if_r;   // fetch the point to move
          state_nxt    = parm_pkg::ST_ENERGY;
        end
      end

      parm_pkg::ST_ENERGY: begin
        // |old| - |new| as one add or subtract on the sign of the new area
        res_de_nxt = new_area_r[AB-1] ? (abs_old_r + new_area_r) : (abs_old_r - new_area_r);
        if (cmd_r == parm_pkg::CMD_APPLY) begin
          area_nxt  = new_area_r;
          moved_nxt = rd_b_r;
          sh_up_nxt = (it_r < if_r);
          if (it_r < if_r) begin
            // entries to .. from-1 advance by one place
            sh_rd_nxt   = if_r - AW'(1);
            sh_left_nxt = if_r - it_r;
            dest_nxt    = it_r;
          end else begin
            // entries from+1 .. to-1 drop back by one place
            sh_rd_nxt   = if_r + AW'(1);
            sh_left_nxt = it_r - if_r - AW'(1);
            dest_nxt    = it_r - AW'(1);
          end
          state_nxt = parm_pkg::ST_SHIFT;
        end else begin
          state_nxt = parm_pkg::ST_DONE;
        end
      end

      parm_pkg::ST_SHIFT: begin
        // write back the entry read last cycle, one place on
        if (sh_wv_r) begin
          mem_we = 1'b1;
          mem_wa = sh_wa_r;
          mem_wd = rd_a_r;
        end
        if (sh_left_r != '0) begin
          ra_a        = sh_rd_r;
          sh_rd_nxt   = sh_up_r ? (sh_rd_r - AW'(1)) : (sh_rd_r + AW'(1));
          sh_left_nxt = sh_left_r - AW'(1);
          sh_wv_nxt   = 1'b1;
          sh_wa_nxt   = sh_up_r ? (sh_rd_r + AW'(1)) : (sh_rd_r - AW'(1));
        end else begin
          state_nxt = parm_pkg::ST_PLACE;
        end
      end

      parm_pkg::ST_PLACE: begin
        mem_we    = 1'b1;
        mem_wa    = dest_r;
        mem_wd    = moved_r;
        state_nxt = parm_pkg::ST_DONE;
      end

      parm_pkg::ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = parm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = parm_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= parm_pkg::ST_IDLE;
      count_r     <= '0;
      area_r      <= '0;
      mac_ctl_r   <= '0;
      sh_wv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      area_r      <= area_nxt;
      mac_ctl_r   <= mac_ctl_nxt;
      sh_wv_r     <= sh_wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ip_r       <= ip_nxt;
    if_r       <= if_nxt;
    inx_r      <= inx_nxt;
    ipt_r      <= ipt_nxt;
    it_r       <= it_nxt;
    k_r        <= k_nxt;
    new_area_r <= new_area_nxt;
    abs_old_r  <= abs_old_nxt;
    res_da_r   <= res_da_nxt;
    res_de_r   <= res_de_nxt;
    res_st_r   <= res_st_nxt;
    moved_r    <= moved_nxt;
    sh_up_r    <= sh_up_nxt;
    sh_rd_r    <= sh_rd_nxt;
    sh_left_r  <= sh_left_nxt;
    sh_wa_r    <= sh_wa_nxt;
    dest_r     <= dest_nxt;
    if (out_load) begin
      out_area_r <= area_r;
      out_da_r   <= res_da_r;
      out_de_r   <= res_de_r;
      out_cnt_r  <= parm_pkg::COUNT_BITS'(count_r);
      out_st_r   <= res_st_r;
    end
  end

  // --------------------------------------------------------------------------
  // Channel ports
  // --------------------------------------------------------------------------
  assign in_ch.ready          = (state_r == parm_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.doubled_area  = out_area_r;
  assign out_ch.area_change   = out_da_r;
  assign out_ch.energy_change = out_de_r;
  assign out_ch.point_count   = out_cnt_r;
  assign out_ch.status        = out_st_r;

`ifndef SYNTHESIS
  // the ring never holds more points than the memory has entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count beyond ring depth");

  // shift and placement writes stay inside the held ring
  a_write_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && ((state_r == parm_pkg::ST_SHIFT) || (state_r == parm_pkg::ST_PLACE)))
      |-> (CW'(mem_wa) < count_r))
    else $error("relocation write outside the ring");

  // a shift never reads the entry it writes in the same cycle
  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == parm_pkg::ST_SHIFT) && mem_we && (sh_left_r != '0)) |-> (mem_wa != ra_a))
    else $error("shift read and write collide");

  // the area moves only on a request, an append update or an applied move
  a_area_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != parm_pkg::ST_IDLE) && (state_r != parm_pkg::ST_AREA) &&
     (state_r != parm_pkg::ST_ENERGY)) |=> $stable(area_r))
    else $error("area changed outside an update step");

  // a finished result waits while the output register is still taken
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == parm_pkg::ST_DONE) && out_valid_r && !out_ch.ready)
      |=> (state_r == parm_pkg::ST_DONE))
    else $error("result dropped while output register busy");
`endif

endmodule
